/* hw/rtl/tfmri_pkg.sv */
// package for the tcp flow match reset injector
// shared types, constants and register indexes; no dependencies
`default_nettype none

package tfmri_pkg;

  localparam int unsigned CaptureBytesDef = 100;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [1:0] CfgLocalIp    = 2'd0;
  localparam logic [1:0] CfgLocalPort  = 2'd1;
  localparam logic [1:0] CfgRemoteIp   = 2'd2;
  localparam logic [1:0] CfgRemotePort = 2'd3;

  localparam logic [15:0] EtherIpv4   = 16'h0800;
  localparam logic [3:0]  IpVersion4  = 4'd4;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [31:0] IpWord0     = 32'h4500_0028;
  localparam logic [31:0] IpWord2     = 32'hFF06_0000;
  localparam logic [15:0] FlagsAck    = 16'h5010;
  localparam logic [15:0] FlagsRstAck = 16'h5014;
  localparam logic [15:0] WindowSize  = 16'd1234;
  localparam logic [19:0] PseudoConst = 20'd26;   // protocol plus tcp length
  localparam logic [3:0]  LastWord    = 4'd9;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] local_port;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic        rst;
  } pkt_req_t;

  typedef struct packed {
    logic armed;
    logic push;
    logic push_rst;
  } front_status_t;

endpackage

`default_nettype wire

/* hw/rtl/tfmri_front.sv */
// front part: takes items, captures header fields, decides on packets
// depends on tfmri_pkg
`default_nettype none

module tfmri_front #(
  parameter int unsigned CaptureBytes = tfmri_pkg::CaptureBytesDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic                   kind_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   frame_end_i,
  input  wire tfmri_pkg::cfg_t        cfg_i,
  output tfmri_pkg::pkt_req_t         req_o,
  output tfmri_pkg::front_status_t    status_o
);

  localparam logic [11:0] CapLimit = 12'(CaptureBytes);

  logic [10:0] bc_q, bc_d;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  ver_q, ver_d, hw_q, hw_d;
  logic [12:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] sip_q, sip_d, dip_q, dip_d, seq_q, seq_d, ack_q, ack_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic        armed_q, armed_d;
  logic        push, match;
  logic [11:0] len, tcp_end;
  logic [11:0] tstart, tcp_off;
  logic        cap;

  always_comb begin
    bc_d = bc_q; eth_d = eth_q; ver_d = ver_q; hw_d = hw_q; frag_d = frag_q;
    proto_d = proto_q; sip_d = sip_q; dip_d = dip_q; sport_d = sport_q;
    dport_d = dport_q; seq_d = seq_q; ack_d = ack_q; armed_d = armed_q;
    push = 1'b0;
    req_o = '0;
    len = {1'b0, bc_q} + 12'd1;
    cap = {1'b0, bc_q} < CapLimit;
    // header length is needed for the tcp offset of this very byte
    if (accept_i && kind_i && armed_q && cap && bc_q == 11'd14) begin
      ver_d = data_byte_i[7:4];
      hw_d  = data_byte_i[3:0];
    end
    tstart = 12'd14 + {6'd0, hw_d, 2'b00};
    tcp_off = {1'b0, bc_q} - tstart;
    tcp_end = tstart + 12'd12;
    if (accept_i) begin
      if (!kind_i) begin
        armed_d = 1'b1;
        bc_d = '0;
        push = 1'b1;
      end else if (armed_q) begin
        if (cap) begin
          if (bc_q == 11'd12) eth_d[15:8] = data_byte_i;
          if (bc_q == 11'd13) eth_d[7:0] = data_byte_i;
          if (bc_q == 11'd20) frag_d[12:8] = data_byte_i[4:0];
          if (bc_q == 11'd21) frag_d[7:0] = data_byte_i;
          if (bc_q == 11'd23) proto_d = data_byte_i;
          if (bc_q >= 11'd26 && bc_q <= 11'd29) sip_d = {sip_q[23:0], data_byte_i};
          if (bc_q >= 11'd30 && bc_q <= 11'd33) dip_d = {dip_q[23:0], data_byte_i};
          if ({1'b0, bc_q} >= tstart) begin
            if (tcp_off <= 12'd1) sport_d = {sport_q[7:0], data_byte_i};
            else if (tcp_off <= 12'd3) dport_d = {dport_q[7:0], data_byte_i};
            else if (tcp_off <= 12'd7) seq_d = {seq_q[23:0], data_byte_i};
            else if (tcp_off <= 12'd11) ack_d = {ack_q[23:0], data_byte_i};
          end
        end
        if (bc_q != 11'h7FF) bc_d = bc_q + 11'd1;
        if (frame_end_i) begin
          bc_d = '0;
          if (match) begin
            armed_d = 1'b0;
            push = 1'b1;
            req_o.seq = ack_d;
            req_o.ack = seq_d;
            req_o.rst = 1'b1;
          end
        end
      end
    end
  end

  assign match = (len >= 12'd40) && (tcp_end <= len) && (tcp_end <= CapLimit)
              && (eth_d == tfmri_pkg::EtherIpv4) && (ver_d == tfmri_pkg::IpVersion4)
              && (frag_d == '0) && (proto_d == tfmri_pkg::ProtoTcp)
              && (sip_d == cfg_i.remote_ip) && (dip_d == cfg_i.local_ip)
              && (sport_d == cfg_i.remote_port) && (dport_d == cfg_i.local_port);

  assign status_o.armed    = armed_q;
  assign status_o.push     = push;
  assign status_o.push_rst = req_o.rst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= '0; eth_q <= '0; ver_q <= '0; hw_q <= '0; frag_q <= '0;
      proto_q <= '0; sip_q <= '0; dip_q <= '0; sport_q <= '0; dport_q <= '0;
      seq_q <= '0; ack_q <= '0; armed_q <= 1'b0;
    end else begin
      bc_q <= bc_d; eth_q <= eth_d; ver_q <= ver_d; hw_q <= hw_d; frag_q <= frag_d;
      proto_q <= proto_d; sip_q <= sip_d; dip_q <= dip_d; sport_q <= sport_d;
      dport_q <= dport_d; seq_q <= seq_d; ack_q <= ack_d; armed_q <= armed_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tfmri_queue.sv */
// short request queue between front and back
// depends on tfmri_pkg
`default_nettype none

module tfmri_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tfmri_pkg::pkt_req_t data_i,
  input  wire logic                pop_i,
  output tfmri_pkg::pkt_req_t      head_o,
  output logic                     empty_o,
  output logic                     full_o,
  output logic [1:0]               count_o
);

  tfmri_pkg::pkt_req_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign head_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'(tfmri_pkg::QueueDepth));
  assign count_o = cnt_q;

endmodule

`default_nettype wire

/* hw/rtl/tfmri_back.sv */
// back part: serializes one packet per request, running tcp checksum
// depends on tfmri_pkg
`default_nettype none

module tfmri_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tfmri_pkg::cfg_t     cfg_i,
  input  wire tfmri_pkg::pkt_req_t head_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [31:0]              packet_word_o,
  output logic                     packet_last_o,
  output logic                     is_reset_o
);

  logic [3:0]  idx_q;
  logic [19:0] acc_q, acc_d;
  logic        vld_q, last_q, rst_q;
  logic [31:0] word_q, word;
  logic        free, load;
  logic [16:0] fold1;
  logic [15:0] fold2, ck;

  assign free = !vld_q || !out_stall_i;
  assign load = free && !empty_i;
  assign pop_o = load && (idx_q == tfmri_pkg::LastWord);

  assign fold1 = {1'b0, acc_q[15:0]} + {13'd0, acc_q[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
  assign ck = (~fold2 == 16'd0) ? 16'hFFFF : ~fold2;

  always_comb begin
    case (idx_q)
      4'd0: word = tfmri_pkg::IpWord0;
      4'd1: word = '0;
      4'd2: word = tfmri_pkg::IpWord2;
      4'd3: word = cfg_i.local_ip;
      4'd4: word = cfg_i.remote_ip;
      4'd5: word = {cfg_i.local_port, cfg_i.remote_port};
      4'd6: word = head_i.seq;
      4'd7: word = head_i.ack;
      4'd8: word = {head_i.rst ? tfmri_pkg::FlagsRstAck : tfmri_pkg::FlagsAck,
                    tfmri_pkg::WindowSize};
      default: word = {ck, 16'd0};
    endcase
    if (idx_q == 4'd0) acc_d = tfmri_pkg::PseudoConst;
    else if (idx_q >= 4'd3 && idx_q <= 4'd8)
      acc_d = acc_q + {4'd0, word[31:16]} + {4'd0, word[15:0]};
    else acc_d = acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word;
      last_q <= (idx_q == tfmri_pkg::LastWord);
      rst_q  <= head_i.rst;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; idx_q <= '0;
    end else if (free) begin
      vld_q <= !empty_i;
      if (load) idx_q <= (idx_q == tfmri_pkg::LastWord) ? 4'd0 : idx_q + 4'd1;
    end
  end

  assign out_valid_o   = vld_q;
  assign packet_word_o = word_q;
  assign packet_last_o = last_q;
  assign is_reset_o    = rst_q;

endmodule

`default_nettype wire

/* hw/rtl/tcp_flow_match_reset_injector.sv */
// top level of the tcp flow match reset injector
// depends on tfmri_pkg, tfmri_front, tfmri_queue, tfmri_back
`default_nettype none

// A start item (kind 0) sends a ten-word IPv4/TCP ACK probe from the local to
// the remote endpoint and arms the block; while armed, frame bytes (kind 1) are
// taken one per cycle and header fields captured. On the last byte of a frame
// from the remote flow an RST+ACK is sent and the block disarms. Input items
// are taken every cycle while the two-entry packet queue has room; each
// packet leaves at one word per cycle while out_stall_i is low, so the back
// end, not the byte path, sets the sustained packet rate. The user must write
// configuration registers only while idle; the block does not enforce this.
module tcp_flow_match_reset_injector #(
  parameter int unsigned CaptureBytes = tfmri_pkg::CaptureBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      packet_word_o,
  output logic             packet_last_o,
  output logic             is_reset_o
);

  tfmri_pkg::cfg_t          cfg_q;
  tfmri_pkg::pkt_req_t      req, head;
  tfmri_pkg::front_status_t fst;
  logic                     accept, q_empty, q_full, pop;
  logic [1:0]               q_count;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfmri_pkg::CfgLocalIp:    cfg_q.local_ip    <= cfg_data_i;
        tfmri_pkg::CfgLocalPort:  cfg_q.local_port  <= cfg_data_i[15:0];
        tfmri_pkg::CfgRemoteIp:   cfg_q.remote_ip   <= cfg_data_i;
        tfmri_pkg::CfgRemotePort: cfg_q.remote_port <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // a transfer is taken whenever the queue can hold a packet request
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  tfmri_front #(.CaptureBytes(CaptureBytes)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .kind_i, .data_byte_i, .frame_end_i,
    .cfg_i(cfg_q), .req_o(req), .status_o(fst)
  );

  tfmri_queue u_queue (
    .clk_i, .rst_ni, .push_i(fst.push), .data_i(req), .pop_i(pop),
    .head_o(head), .empty_o(q_empty), .full_o(q_full), .count_o(q_count)
  );

  // back end walks the packet words of the queue head
  tfmri_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .head_i(head), .empty_i(q_empty),
    .pop_o(pop), .out_valid_o, .out_stall_i, .packet_word_o, .packet_last_o,
    .is_reset_o
  );

  // checksum word never carries a zero checksum and has zero low half
  a_ck_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_last_o |-> packet_word_o[31:16] != 16'd0
      && packet_word_o[15:0] == 16'd0) else $error("bad checksum word");

  // sending a reset disarms the front
  a_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fst.push && fst.push_rst |=> !fst.armed) else $error("still armed after rst");

  // queue never overfills
  a_qcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= 2'(tfmri_pkg::QueueDepth)) else $error("queue overflow");

endmodule

`default_nettype wire
